// ----- rtl/i2cms_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master write-then-read sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // Write buffer geometry (power of two).
    localparam int WBUF_DEPTH = 64;
    localparam int WBUF_AW    = $clog2(WBUF_DEPTH);

    localparam int LEN_W  = 7;
    localparam int RLEN_W = 16;

    // Request queue between the front and the back end.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_TIMEOUT = 1'b0;
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;

    // Request kinds.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Engine event classes after priority decode.
    localparam logic [1:0] EV_ACK    = 2'd0;
    localparam logic [1:0] EV_RX     = 2'd1;
    localparam logic [1:0] EV_NONE   = 2'd2;
    localparam logic [1:0] EV_FINISH = 2'd3;

    // Engine commands.
    localparam logic [2:0] CMD_SEND    = 3'd0;
    localparam logic [2:0] CMD_RX_ACK  = 3'd1;
    localparam logic [2:0] CMD_RX_NACK = 3'd2;
    localparam logic [2:0] CMD_START   = 3'd3;
    localparam logic [2:0] CMD_RESTART = 3'd4;
    localparam logic [2:0] CMD_STOP    = 3'd5;

    typedef struct packed {
        logic [1:0]        op;
        logic [5:0]        index;
        logic [7:0]        wbyte;
        logic [6:0]        slave_addr;
        logic [LEN_W-1:0]  write_len;
        logic [LEN_W-1:0]  write_len2;
        logic [RLEN_W-1:0] read_len;
        logic              ack_flag;
        logic              start_seen;
        logic              rx_flag;
        logic              stop_seen;
        logic [7:0]        rx_byte;
    } t_in_item;

    typedef struct packed {
        logic              cmd_valid;
        logic [2:0]        cmd_code;
        logic [7:0]        cmd_data;
        logic              rd_valid;
        logic [7:0]        rd_data;
        logic              done_res;
        logic              acked;
        logic [RLEN_W-1:0] read_count;
        logic              timed_out;
        logic              busy_res;
        logic              start_rejected;
        logic [31:0]       error_count;
    } t_out_item;

    // Classified request as it travels through the queue.
    typedef struct packed {
        logic [1:0]         op;
        logic [WBUF_AW-1:0] index;
        logic [7:0]         wbyte;
        logic [6:0]         slave_addr;
        logic [LEN_W-1:0]   len1;
        logic [LEN_W-1:0]   len2;
        logic [RLEN_W-1:0]  read_len;
        logic               empty_start;
        logic [1:0]         ev;
        logic               start_seen;
        logic [7:0]         rx_byte;
    } t_req;

endpackage
`default_nettype wire

// ----- rtl/i2c_master_transaction_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Sequences one combined write-then-read I2C transaction over a byte engine.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_stall / i_in_data) carries one request
// per item: a write-buffer load, a transaction start, an engine status event
// or a timer tick. The output channel (o_out_valid / i_out_stall / o_out_data)
// returns exactly one result per request, in order: the next engine command,
// a delivered read byte, completion status and the timeout error count.
// An accepted request is registered into the request queue; the back end then
// registers its result into the output register. Sustained throughput is one
// request per cycle while the receiver does not stall; the back end retires
// one queued request per cycle, paced by its single state update.
// When the receiver stalls, the result holds in the output register and the
// four-entry request queue absorbs new requests until it fills, then
// o_in_stall rises. Reset empties the queue, drops any transaction and clears
// the error count; the timeout register returns to 10 ticks. The write buffer
// holds unknown data until loaded. The APB port holds the timeout register at
// address 0; the user must write it only while idle, which is not enforced.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer
    import i2cms_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic       timeout_sel;
    logic [7:0] r_timeout;
    logic       q_full;
    logic       q_empty;
    logic       push;
    logic       pop;
    t_req       front_req;
    t_req       head_req;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[PADDR_W-1] == REG_TIMEOUT) begin
            r_timeout <= pwdata[7:0];
        end
    end

    assign timeout_sel = (paddr[PADDR_W-1] == REG_TIMEOUT);
    assign prdata = timeout_sel ? {24'd0, r_timeout} : 32'd0;

    i2cms_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_req      (front_req)
    );

    i2cms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_req   (head_req)
    );

    i2cms_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_req           (head_req),
        .i_timeout_ticks (r_timeout),
        .i_out_stall     (i_out_stall),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .o_out_data      (o_out_data)
    );

endmodule
`default_nettype wire

// ----- rtl/i2cms_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address write).
// ----------------------------------------------------------------------------
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/i2cms_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_front
// Accepts input requests, clamps the segment lengths and decodes the engine
// status flags into one event class.
// ----------------------------------------------------------------------------
module i2cms_front
    import i2cms_pkg::*;
(
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_data,
    input  wire logic     i_q_full,
    output logic          o_in_stall,
    output logic          o_push,
    output t_req          o_req
);

    logic [LEN_W-1:0] len1;
    logic [LEN_W-1:0] len2_raw;
    logic [LEN_W-1:0] space;
    logic [1:0]       ev;

    always_comb begin
        len1 = (i_in_data.write_len > LEN_W'(WBUF_DEPTH)) ? LEN_W'(WBUF_DEPTH)
                                                            : i_in_data.write_len;
        // An empty first segment drops the second one.
        len2_raw = (len1 == '0) ? '0 : i_in_data.write_len2;
        space    = LEN_W'(WBUF_DEPTH) - len1;

        priority if (i_in_data.ack_flag) begin
            ev = EV_ACK;
        end else if (i_in_data.rx_flag) begin
            ev = EV_RX;
        end else if (!i_in_data.stop_seen) begin
            ev = EV_NONE;
        end else begin
            ev = EV_FINISH;
        end
    end

    always_comb begin
        o_req.op          = i_in_data.op;
        o_req.index       = i_in_data.index[WBUF_AW-1:0];
        o_req.wbyte       = i_in_data.wbyte;
        o_req.slave_addr  = i_in_data.slave_addr;
        o_req.len1        = len1;
        o_req.len2        = (len2_raw > space) ? space : len2_raw;
        o_req.read_len    = i_in_data.read_len;
        o_req.empty_start = (i_in_data.write_len == '0) && (i_in_data.read_len == '0);
        o_req.ev          = ev;
        o_req.start_seen  = i_in_data.start_seen;
        o_req.rx_byte     = i_in_data.rx_byte;
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule
`default_nettype wire

// ----- rtl/i2cms_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_queue
// Short FIFO of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
module i2cms_queue
    import i2cms_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_req,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_req      o_req
);

    t_req            r_slot [QDEPTH];
    logic [QAW-1:0]  r_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr;
    logic [QCW-1:0]  r_count;
    logic [QCW-1:0]  n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_req;
        end
    end

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_req   = r_slot[r_rd_ptr];

endmodule
`default_nettype wire

// ----- rtl/i2cms_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_back
// Executes one queued request per cycle while the output is not stalled
// against the transaction state and holds the result in an output register.
// ----------------------------------------------------------------------------
module i2cms_back
    import i2cms_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_empty,
    input  wire t_req       i_req,
    input  wire logic [7:0] i_timeout_ticks,
    input  wire logic       i_out_stall,
    output logic            o_pop,
    output logic            o_out_valid,
    output t_out_item       o_out_data
);

    logic [WBUF_AW-1:0] r_wptr,      n_wptr;
    logic [LEN_W-1:0]   r_first_rem, n_first_rem;
    logic [LEN_W-1:0]   r_second_rem, n_second_rem;
    logic [RLEN_W-1:0]  r_read_rem,  n_read_rem;
    logic [RLEN_W-1:0]  r_read_total, n_read_total;
    logic [6:0]         r_addr,      n_addr;
    logic               r_active,    n_active;
    logic               r_ack_seen,  n_ack_seen;
    logic               r_evt,       n_evt;
    logic [7:0]         r_idle,      n_idle;
    logic [31:0]        r_tcount,    n_tcount;

    logic               r_out_valid;
    t_out_item          r_out,       n_out;

    logic               r_byp_valid;
    logic [7:0]         r_byp_data;
    logic [7:0]         ram_rdata;
    logic [7:0]         buf_byte;
    logic               we;
    logic               fire;
    logic [7:0]         idle_inc;

    assign fire  = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_pop = fire;
    assign we    = fire && (i_req.op == OP_LOAD);

    // The RAM always reads the entry the pointer will hold next cycle; a load
    // to that same entry in this cycle is forwarded around the RAM.
    assign buf_byte = r_byp_valid ? r_byp_data : ram_rdata;

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (WBUF_DEPTH)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_req.index),
        .i_wdata (i_req.wbyte),
        .i_raddr (n_wptr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_wptr       = r_wptr;
        n_first_rem  = r_first_rem;
        n_second_rem = r_second_rem;
        n_read_rem   = r_read_rem;
        n_read_total = r_read_total;
        n_addr       = r_addr;
        n_active     = r_active;
        n_ack_seen   = r_ack_seen;
        n_evt        = r_evt;
        n_idle       = r_idle;
        n_tcount     = r_tcount;
        n_out        = '0;
        idle_inc     = (r_idle == 8'hFF) ? r_idle : r_idle + 8'd1;

        if (fire) begin
            unique case (i_req.op)
                OP_LOAD: begin
                end
                OP_START: begin
                    if (r_active || i_req.empty_start) begin
                        n_out.start_rejected = 1'b1;
                    end else begin
                        n_first_rem  = i_req.len1;
                        n_second_rem = i_req.len2;
                        n_wptr       = '0;
                        n_read_rem   = i_req.read_len;
                        n_read_total = i_req.read_len;
                        n_addr       = i_req.slave_addr;
                        n_active     = 1'b1;
                        n_ack_seen   = 1'b0;
                        n_evt        = 1'b0;
                        n_idle       = '0;
                        n_out.cmd_valid = 1'b1;
                        n_out.cmd_code  = CMD_START;
                        n_out.cmd_data  = {i_req.slave_addr, (i_req.len1 == '0)};
                    end
                end
                OP_EVENT: begin
                    if (r_active) begin
                        unique case (i_req.ev)
                            EV_ACK: begin
                                n_evt = 1'b1;
                                n_out.cmd_valid = 1'b1;
                                if (r_first_rem != '0) begin
                                    n_out.cmd_code = CMD_SEND;
                                    n_out.cmd_data = buf_byte;
                                    n_wptr         = r_wptr + WBUF_AW'(1);
                                    n_ack_seen     = 1'b1;
                                    // Chain into the second segment when the
                                    // first one runs out.
                                    if (r_first_rem == LEN_W'(1) && r_second_rem != '0) begin
                                        n_first_rem  = r_second_rem;
                                        n_second_rem = '0;
                                    end else begin
                                        n_first_rem = r_first_rem - LEN_W'(1);
                                    end
                                end else if (r_read_rem != '0) begin
                                    if (i_req.start_seen) begin
                                        n_out.cmd_code = CMD_RX_ACK;
                                    end else begin
                                        n_out.cmd_code = CMD_RESTART;
                                        n_out.cmd_data = {r_addr, 1'b1};
                                    end
                                end else begin
                                    n_out.cmd_code = CMD_STOP;
                                end
                            end
                            EV_RX: begin
                                n_evt = 1'b1;
                                n_out.cmd_valid = 1'b1;
                                if (r_read_rem != '0) begin
                                    n_out.rd_valid = 1'b1;
                                    n_out.rd_data  = i_req.rx_byte;
                                    n_read_rem     = r_read_rem - RLEN_W'(1);
                                end
                                n_out.cmd_code = (n_read_rem != '0) ? CMD_RX_ACK
                                                                     : CMD_RX_NACK;
                            end
                            EV_NONE: begin
                                n_out.cmd_valid = 1'b1;
                                n_out.cmd_code  = CMD_STOP;
                            end
                            EV_FINISH: begin
                                n_out.done_res   = 1'b1;
                                n_out.read_count = r_read_total - r_read_rem;
                                n_active         = 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                OP_TICK: begin
                    if (r_active && !r_evt) begin
                        n_idle = idle_inc;
                        if (idle_inc >= i_timeout_ticks) begin
                            n_tcount         = r_tcount + 32'd1;
                            n_out.timed_out  = 1'b1;
                            n_out.done_res   = 1'b1;
                            n_out.read_count = r_read_total - r_read_rem;
                            n_active         = 1'b0;
                            n_idle           = '0;
                        end
                    end else begin
                        n_evt  = 1'b0;
                        n_idle = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        n_out.acked       = n_ack_seen;
        n_out.busy_res    = n_active;
        n_out.error_count = n_tcount;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr       <= '0;
            r_first_rem  <= '0;
            r_second_rem <= '0;
            r_read_rem   <= '0;
            r_read_total <= '0;
            r_addr       <= '0;
            r_active     <= 1'b0;
            r_ack_seen   <= 1'b0;
            r_evt        <= 1'b0;
            r_idle       <= '0;
            r_tcount     <= '0;
            r_out_valid  <= 1'b0;
            r_byp_valid  <= 1'b0;
        end else begin
            r_wptr       <= n_wptr;
            r_first_rem  <= n_first_rem;
            r_second_rem <= n_second_rem;
            r_read_rem   <= n_read_rem;
            r_read_total <= n_read_total;
            r_addr       <= n_addr;
            r_active     <= n_active;
            r_ack_seen   <= n_ack_seen;
            r_evt        <= n_evt;
            r_idle       <= n_idle;
            r_tcount     <= n_tcount;
            r_byp_valid  <= we && (i_req.index == n_wptr);
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_req.wbyte;
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- tb/sv/tb_i2c_master_transaction_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transaction_sequencer
// Self-checking testbench for the I2C write-then-read transaction sequencer.
// Every request is predicted by a behavioral copy of the sequencer, and each
// result is compared field by field in arrival order. Directed requests cover
// the corner cases. Random phases then drive engine-like event sequences
// under different timeout settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_sequencer;
    import i2cms_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    t_in_item           in_data = '0;
    logic               out_stall = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic [31:0]        prdata;
    logic               pready;

    i2c_master_transaction_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Behavioral copy of the sequencer state.
    logic [7:0]  seq_buf [WBUF_DEPTH];
    logic [5:0]  seq_wr_ptr = '0;
    logic [6:0]  seq_seg_left = '0;
    logic [6:0]  seq_seg2_left = '0;
    logic [15:0] seq_reads_left = '0;
    logic [15:0] seq_reads_total = '0;
    logic [6:0]  seq_addr = '0;
    logic        seq_busy = 1'b0;
    logic        seq_acked = 1'b0;
    logic        seq_event_seen = 1'b0;
    logic [7:0]  seq_idle_ticks = '0;
    logic [31:0] seq_timeouts = '0;
    logic [7:0]  seq_timeout_cfg = TIMEOUT_RESET;

    t_out_item   expected_results [$];
    int unsigned fail_count = 0;
    int unsigned requests_sent = 0;
    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 86;
    logic        hold_off = 1'b0;

    function automatic t_out_item predict_result(input t_in_item req);
        t_out_item   res;
        int unsigned len1;
        int unsigned len2;
        logic [7:0]  limit;
        res = '0;
        case (req.op)
            OP_LOAD: begin
                seq_buf[req.index] = req.wbyte;
            end
            OP_START: begin
                len1 = req.write_len;
                len2 = req.write_len2;
                if (seq_busy || (len1 == 0 && req.read_len == 0)) begin
                    res.start_rejected = 1'b1;
                end else begin
                    if (len1 > WBUF_DEPTH) len1 = WBUF_DEPTH;
                    // An empty first segment drops the second one.
                    if (len1 == 0) len2 = 0;
                    if (len2 > WBUF_DEPTH - len1) len2 = WBUF_DEPTH - len1;
                    seq_seg_left    = 7'(len1);
                    seq_seg2_left   = 7'(len2);
                    seq_wr_ptr      = '0;
                    seq_reads_left  = req.read_len;
                    seq_reads_total = req.read_len;
                    seq_addr        = req.slave_addr;
                    seq_busy        = 1'b1;
                    seq_acked       = 1'b0;
                    seq_event_seen  = 1'b0;
                    seq_idle_ticks  = '0;
                    res.cmd_valid   = 1'b1;
                    res.cmd_code    = CMD_START;
                    res.cmd_data    = {req.slave_addr, len1 == 0};
                end
            end
            OP_EVENT: begin
                if (seq_busy) begin
                    if (req.ack_flag) begin
                        seq_event_seen = 1'b1;
                        res.cmd_valid  = 1'b1;
                        if (seq_seg_left != 0) begin
                            res.cmd_code = CMD_SEND;
                            res.cmd_data = seq_buf[seq_wr_ptr];
                            seq_wr_ptr   = seq_wr_ptr + 6'd1;
                            seq_seg_left = seq_seg_left - 7'd1;
                            seq_acked    = 1'b1;
                            if (seq_seg_left == 0 && seq_seg2_left != 0) begin
                                seq_seg_left  = seq_seg2_left;
                                seq_seg2_left = '0;
                            end
                        end else if (seq_reads_left != 0) begin
                            if (req.start_seen) begin
                                res.cmd_code = CMD_RX_ACK;
                            end else begin
                                res.cmd_code = CMD_RESTART;
                                res.cmd_data = {seq_addr, 1'b1};
                            end
                        end else begin
                            res.cmd_code = CMD_STOP;
                        end
                    end else if (req.rx_flag) begin
                        seq_event_seen = 1'b1;
                        if (seq_reads_left != 0) begin
                            res.rd_valid   = 1'b1;
                            res.rd_data    = req.rx_byte;
                            seq_reads_left = seq_reads_left - 16'd1;
                        end
                        res.cmd_valid = 1'b1;
                        res.cmd_code  = (seq_reads_left != 0) ? CMD_RX_ACK : CMD_RX_NACK;
                    end else if (!req.stop_seen) begin
                        res.cmd_valid = 1'b1;
                        res.cmd_code  = CMD_STOP;
                    end else begin
                        res.done_res   = 1'b1;
                        res.read_count = seq_reads_total - seq_reads_left;
                        seq_busy       = 1'b0;
                    end
                end
            end
            default: begin
                limit = (seq_timeout_cfg == 0) ? 8'd1 : seq_timeout_cfg;
                if (seq_busy && !seq_event_seen) begin
                    if (seq_idle_ticks != 8'hFF) seq_idle_ticks = seq_idle_ticks + 8'd1;
                    if (seq_idle_ticks >= limit) begin
                        seq_timeouts   = seq_timeouts + 32'd1;
                        res.timed_out  = 1'b1;
                        res.done_res   = 1'b1;
                        res.read_count = seq_reads_total - seq_reads_left;
                        seq_busy       = 1'b0;
                        seq_idle_ticks = '0;
                    end
                end else begin
                    seq_event_seen = 1'b0;
                    seq_idle_ticks = '0;
                end
            end
        endcase
        res.acked       = seq_acked;
        res.busy_res    = seq_busy;
        res.error_count = seq_timeouts;
        return res;
    endfunction

    // Fields that the operation does not use still carry random values.
    function automatic t_in_item random_request(input logic [1:0] op);
        t_in_item r;
        r.op         = op;
        r.index      = 6'($urandom);
        r.wbyte      = 8'($urandom);
        r.slave_addr = 7'($urandom);
        r.write_len  = 7'($urandom_range(0, 64));
        r.write_len2 = 7'($urandom_range(0, 64));
        r.read_len   = 16'($urandom);
        r.ack_flag   = 1'($urandom);
        r.start_seen = 1'($urandom);
        r.rx_flag    = 1'($urandom);
        r.stop_seen  = 1'($urandom);
        r.rx_byte    = 8'($urandom);
        return r;
    endfunction

    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        expected_results.push_back(predict_result(req));
        requests_sent++;
    endtask

    task automatic send_load(input logic [5:0] idx, input logic [7:0] data);
        t_in_item r;
        r = random_request(OP_LOAD);
        r.index = idx;
        r.wbyte = data;
        send_request(r);
    endtask

    task automatic send_start(input logic [6:0] addr, input logic [6:0] len1,
                              input logic [6:0] len2, input logic [15:0] rlen);
        t_in_item r;
        r = random_request(OP_START);
        r.slave_addr = addr;
        r.write_len  = len1;
        r.write_len2 = len2;
        r.read_len   = rlen;
        send_request(r);
    endtask

    task automatic send_event(input logic ack, input logic st, input logic rx,
                              input logic sp, input logic [7:0] data);
        t_in_item r;
        r = random_request(OP_EVENT);
        r.ack_flag   = ack;
        r.start_seen = st;
        r.rx_flag    = rx;
        r.stop_seen  = sp;
        r.rx_byte    = data;
        send_request(r);
    endtask

    task automatic send_tick();
        send_request(random_request(OP_TICK));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_timeout_reg(input logic [7:0] ticks);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TIMEOUT, 2'b00};
        pwdata  <= {24'd0, ticks};
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        seq_timeout_cfg = ticks;
        @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: %h", o_out_data);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("cmd_valid", want.cmd_valid, o_out_data.cmd_valid);
                compare_field("cmd_code", want.cmd_code, o_out_data.cmd_code);
                compare_field("cmd_data", want.cmd_data, o_out_data.cmd_data);
                compare_field("rd_valid", want.rd_valid, o_out_data.rd_valid);
                compare_field("rd_data", want.rd_data, o_out_data.rd_data);
                compare_field("done_res", want.done_res, o_out_data.done_res);
                compare_field("acked", want.acked, o_out_data.acked);
                compare_field("read_count", want.read_count, o_out_data.read_count);
                compare_field("timed_out", want.timed_out, o_out_data.timed_out);
                compare_field("busy_res", want.busy_res, o_out_data.busy_res);
                compare_field("start_rejected", want.start_rejected,
                              o_out_data.start_rejected);
                compare_field("error_count", want.error_count, o_out_data.error_count);
            end
        end
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Every buffer entry is loaded first, so no transaction sends stale data.
    task automatic test_buffer_preload();
        for (int i = 0; i < WBUF_DEPTH; i++) begin
            send_load(6'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
        end
    endtask

    task automatic test_write_read_transaction();
        send_start(7'h7F, 7'd2, 7'd1, 16'd2);
        repeat (3) send_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        send_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        send_event(1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
        send_event(1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
        send_event(1'b0, 1'b0, 1'b1, 1'b0, 8'hFF);
        // A byte beyond the read length is dropped and answered with a NACK.
        send_event(1'b0, 1'b0, 1'b1, 1'b0, 8'hA5);
        send_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
        send_event(1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
    endtask

    task automatic test_start_rejects();
        // The second segment alone does not make a transfer.
        send_start(7'h2A, 7'd0, 7'd5, 16'd0);
        send_start(7'h55, 7'd0, 7'd64, 16'd1);
        send_start(7'h00, 7'd1, 7'd1, 16'd1);
        send_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
        send_event(1'b0, 1'b0, 1'b1, 1'b0, 8'h3C);
        send_event(1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
    endtask

    task automatic test_idle_requests();
        send_event(1'b1, 1'b1, 1'b1, 1'b0, 8'h12);
        send_tick();
    endtask

    task automatic test_timeout();
        drain_results();
        write_timeout_reg(8'd1);
        // Both segments at full depth: the second one is clamped to nothing.
        send_start(7'h00, 7'd64, 7'd64, 16'd0);
        // Acknowledge wins over every other flag.
        send_event(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
        send_tick();
        send_tick();
    endtask

    task automatic run_random_transaction();
        int unsigned len1;
        int unsigned len2;
        int unsigned rlen;
        int unsigned steps;
        bit          abandon;
        bit          restarted;
        bit          receiving;
        bit          stop_sent;
        repeat ($urandom_range(0, 3)) send_load(6'($urandom), 8'($urandom));
        if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 1) != 0) send_tick();
            else send_event(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                            8'($urandom));
        end
        len1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 4);
        len2 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 4);
        rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
        send_start(7'($urandom), 7'(len1), 7'(len2), 16'(rlen));
        abandon   = ($urandom_range(0, 9) == 0);
        restarted = (len1 == 0) && ($urandom_range(0, 1) != 0);
        receiving = 1'b0;
        stop_sent = 1'b0;
        steps     = 0;
        while (seq_busy) begin
            steps++;
            if (abandon) begin
                send_tick();
            end else if (steps > 40) begin
                send_event(1'b0, 1'($urandom), 1'b0, 1'b1, 8'($urandom));
            end else begin
                case ($urandom_range(0, 19))
                    0: send_tick();
                    1: send_request(random_request(OP_EVENT));
                    2: send_request(random_request(OP_START));
                    3: send_load(6'($urandom), 8'($urandom));
                    default: begin
                        if (seq_seg_left != 0) begin
                            send_event(1'b1, 1'($urandom), 1'b0, 1'b0, 8'($urandom));
                        end else if (seq_reads_left != 0) begin
                            if (!restarted) begin
                                send_event(1'b1, 1'b0, 1'b0, 1'b0, 8'($urandom));
                                restarted = 1'b1;
                            end else if (!receiving) begin
                                send_event(1'b1, 1'b1, 1'b0, 1'b0, 8'($urandom));
                                receiving = 1'b1;
                            end else begin
                                send_event(1'b0, 1'($urandom), 1'b1, 1'($urandom),
                                           8'($urandom));
                            end
                        end else if (!stop_sent) begin
                            send_event(1'b0, 1'($urandom), 1'b0, 1'b0, 8'($urandom));
                            stop_sent = 1'b1;
                        end else begin
                            send_event(1'b0, 1'($urandom), 1'b0, 1'b1, 8'($urandom));
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [7:0] ticks, input int unsigned count);
        int unsigned target;
        drain_results();
        write_timeout_reg(ticks);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = requests_sent + count;
        while (requests_sent < target) run_random_transaction();
    endtask

    // The receiver holds off while requests keep coming, so the queue fills.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (40) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                repeat (16) send_load(6'($urandom), 8'($urandom));
            end
        join
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_buffer_preload();
        test_write_read_transaction();
        test_start_rejects();
        test_idle_requests();
        test_timeout();
        test_random_phase(15, 86, 8'd4, 140);
        test_random_phase(86, 15, 8'd255, 100);
        test_random_phase(0, 0, 8'($urandom_range(2, 30)), 140);
        test_backpressure();
        drain_results();
        if (fail_count == 0) begin
            $display("tb_i2c_master_transaction_sequencer OK");
        end else begin
            $display("tb_i2c_master_transaction_sequencer NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_i2c_master_transaction_sequencer NOT OK");
        $finish;
    end

endmodule
